### hw/rtl/ezr_pkg.sv
// Package: shared types and constants of the Z-X-Y rotation matrix block.
`default_nettype none
package ezr_pkg;

   localparam int ANGLE_W = 21;
   localparam int ELEM_W  = 16;
   localparam int Q_W     = 32;   // signed Q30 values within +-2

   localparam logic [31:0] DEG_TO_PHASE = 32'd3054198966;
   localparam logic [31:0] RAD_TO_PHASE = 32'd683565276;
   localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
   localparam logic signed [Q_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam logic signed [Q_W-1:0] ONE_Q30 = 32'sd1073741824;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [Q_W-1:0]     q30_type;
   typedef logic signed [ELEM_W-1:0]  elem_type;

   typedef struct packed {
      angle_type angle_z;
      angle_type angle_x;
      angle_type angle_y;
      logic      in_degrees;
   } front_item_type;

   typedef struct packed {
      q30_type sz, cz, sx, cx, sy, cy;
   } trig_type;

   function automatic q30_type atan_q30(input int i);
      unique case (i)
         0: return 32'sh3243F6A8;  1: return 32'sh1DAC6705;
         2: return 32'sh0FADBAFC;  3: return 32'sh07F56EA6;
         4: return 32'sh03FEAB76;  5: return 32'sh01FFD55B;
         6: return 32'sh00FFFAAA;  7: return 32'sh007FFF55;
         8: return 32'sh003FFFEA;  9: return 32'sh001FFFFD;
         10: return 32'sh000FFFFF; 11: return 32'sh0007FFFF;
         12: return 32'sh0003FFFF; 13: return 32'sh0001FFFF;
         14: return 32'sh0000FFFF; 15: return 32'sh00007FFF;
         16: return 32'sh00003FFF; 17: return 32'sh00001FFF;
         18: return 32'sh00000FFF; 19: return 32'sh000007FF;
         20: return 32'sh000003FF; 21: return 32'sh000001FF;
         22: return 32'sh000000FF; 23: return 32'sh0000007F;
         default: return '0;
      endcase
   endfunction

   // round(a*b / 2^30), floor shift
   function automatic q30_type mulq(input q30_type a, input q30_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd536870912;
      return q30_type'(p >>> 30);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/euler_zxy_rotation_matrix.sv
// Top level: Z-X-Y Euler angles to rotation matrix.
// Pipeline: phase, fold, TRIG_STEPS CORDIC stages, two product stages and the output
// register; the front queue reads through.
// Throughput: one request per cycle while not stalled; the CORDIC stage chain sets the depth.
// Whole pipeline advances while the output register is free or being taken.
// Synchronous reset clears valids and queue pointers and sets degrees mode.
`default_nettype none
module euler_zxy_rotation_matrix
   import ezr_pkg::*;
#(
   parameter int TRIG_STEPS    = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,  // angle_z, angle_x, angle_y, pad
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [143:0]      rsp_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_data    // angle_in_degrees in bit 0
);
   localparam int LAT = TRIG_STEPS + 5;

   logic deg_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock)
      if (reset) deg_ff <= 1'b1;
      else if (csr_valid) deg_ff <= csr_data[0];

   front_item_type fi, fo;
   logic f_valid, f_ready;
   always_comb begin
      fi.angle_z = req_tdata[20:0];
      fi.angle_x = req_tdata[41:21];
      fi.angle_y = req_tdata[62:42];
      fi.in_degrees = deg_ff;
   end

   ezr_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_item(fi),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(fo)
   );

   logic en;
   logic [LAT-1:0] v_ff;
   assign en = !rsp_tvalid || rsp_tready;
   assign f_ready = en;
   always_ff @(posedge clock)
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[LAT-2:0], f_valid};

   trig_type tr;
   ezr_trig #(.TRIG_STEPS(TRIG_STEPS)) u_tz (.clock, .en, .angle(fo.angle_z),
      .in_degrees(fo.in_degrees), .sin_o(tr.sz), .cos_o(tr.cz));
   ezr_trig #(.TRIG_STEPS(TRIG_STEPS)) u_tx (.clock, .en, .angle(fo.angle_x),
      .in_degrees(fo.in_degrees), .sin_o(tr.sx), .cos_o(tr.cx));
   ezr_trig #(.TRIG_STEPS(TRIG_STEPS)) u_ty (.clock, .en, .angle(fo.angle_y),
      .in_degrees(fo.in_degrees), .sin_o(tr.sy), .cos_o(tr.cy));

   elem_type m [9];
   ezr_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (.clock, .en, .t(tr), .m);

   logic [143:0] out_ff;
   always_ff @(posedge clock) if (en) begin
      for (int k = 0; k < 9; k++) out_ff[k*16 +: 16] <= m[k];
   end
   assign rsp_tdata  = out_ff;
   assign rsp_tvalid = v_ff[LAT-1];
endmodule
`default_nettype wire

### hw/rtl/ezr_front.sv
// Front end: request capture and a small queue to the datapath; each item carries its unit flag.
`default_nettype none
module ezr_front
   import ezr_pkg::*;
#(
   parameter int DEPTH_LOG2 = 2
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire front_item_type in_item,
   output logic                out_valid,
   input  wire logic           out_ready,
   output front_item_type      out_item
);
   localparam int DEPTH = 1 << DEPTH_LOG2;

   front_item_type mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [DEPTH_LOG2:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != (DEPTH_LOG2+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (DEPTH_LOG2+1)'(push) - (DEPTH_LOG2+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end
endmodule
`default_nettype wire

### hw/rtl/ezr_trig.sv
// Pipelined sine/cosine: phase scaling, quadrant fold, CORDIC stages.
`default_nettype none
module ezr_trig
   import ezr_pkg::*;
#(
   parameter int TRIG_STEPS = 16
) (
   input  wire logic      clock,
   input  wire logic      en,
   input  wire angle_type angle,
   input  wire logic      in_degrees,
   output q30_type        sin_o,
   output q30_type        cos_o
);
   localparam int NS = TRIG_STEPS + 1;
   // stage 0: phase
   logic [31:0] ph_ff;
   logic signed [63:0] prod;
   always_comb prod = 64'(angle) * $signed({32'd0, in_degrees ? DEG_TO_PHASE : RAD_TO_PHASE})
                      + 64'sd32768;
   always_ff @(posedge clock) if (en) ph_ff <= prod[47:16];

   // stage 1: fold and scale residual
   logic [31:0] sh;
   logic signed [30:0] r;
   logic signed [63:0] tp;
   logic [1:0] q_ff;
   q30_type z0_ff;
   always_comb begin
      sh = ph_ff + 32'h2000_0000;
      r  = $signed({1'b0, sh[29:0]}) - 31'sd536870912;
      tp = 64'(r) * 64'($signed({1'b0, HALF_PI_Q30})) + 64'sd536870912;
   end
   always_ff @(posedge clock) if (en) begin
      q_ff  <= sh[31:30];
      z0_ff <= q30_type'(tp >>> 30);
   end

   q30_type x_ff [NS];
   q30_type y_ff [NS];
   q30_type z_ff [NS];
   logic [1:0] qd_ff [NS];
   always_comb begin
      x_ff[0] = CORDIC_GAIN_Q30; y_ff[0] = '0; z_ff[0] = z0_ff; qd_ff[0] = q_ff;
   end
   for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_step
      always_ff @(posedge clock) if (en) begin
         if (!z_ff[i][Q_W-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_q30(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_q30(i);
         end
         qd_ff[i+1] <= qd_ff[i];
      end
   end

   q30_type s, c;
   always_comb begin
      s = y_ff[TRIG_STEPS];
      c = x_ff[TRIG_STEPS];
      if (s > ONE_Q30) s = ONE_Q30; else if (s < -ONE_Q30) s = -ONE_Q30;
      if (c > ONE_Q30) c = ONE_Q30; else if (c < -ONE_Q30) c = -ONE_Q30;
      unique case (qd_ff[TRIG_STEPS])
         2'd0: begin sin_o = s;  cos_o = c;  end
         2'd1: begin sin_o = c;  cos_o = -s; end
         2'd2: begin sin_o = -s; cos_o = -c; end
         default: begin sin_o = -c; cos_o = s; end
      endcase
   end
endmodule
`default_nettype wire

### hw/rtl/ezr_matrix.sv
// Matrix products, rounding and saturation, two product stages.
`default_nettype none
module ezr_matrix
   import ezr_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 14
) (
   input  wire logic     clock,
   input  wire logic     en,
   input  wire trig_type t,
   output elem_type      m [9]
);
   trig_type t_ff;
   q30_type sxsy_ff, sxcy_ff;
   q30_type e_ff [9];

   always_ff @(posedge clock) if (en) begin
      t_ff    <= t;
      sxsy_ff <= mulq(t.sx, t.sy);
      sxcy_ff <= mulq(t.sx, t.cy);
   end

   always_ff @(posedge clock) if (en) begin
      e_ff[0] <= mulq(t_ff.cy, t_ff.cz) - mulq(sxsy_ff, t_ff.sz);
      e_ff[1] <= -mulq(t_ff.cx, t_ff.sz);
      e_ff[2] <= mulq(sxcy_ff, t_ff.sz) + mulq(t_ff.sy, t_ff.cz);
      e_ff[3] <= mulq(t_ff.cy, t_ff.sz) + mulq(sxsy_ff, t_ff.cz);
      e_ff[4] <= mulq(t_ff.cx, t_ff.cz);
      e_ff[5] <= mulq(t_ff.sy, t_ff.sz) - mulq(sxcy_ff, t_ff.cz);
      e_ff[6] <= -mulq(t_ff.cx, t_ff.sy);
      e_ff[7] <= t_ff.sx;
      e_ff[8] <= mulq(t_ff.cx, t_ff.cy);
   end

   localparam int SH = 30 - OUT_FRAC_BITS;
   localparam logic signed [33:0] LIM = 34'sd1 <<< OUT_FRAC_BITS;
   for (genvar k = 0; k < 9; k++) begin : g_fin
      logic signed [33:0] v, rr;
      always_comb begin
         v  = 34'(e_ff[k]);
         if (SH > 0) rr = (v + (34'sd1 <<< (SH > 0 ? SH-1 : 0))) >>> SH;
         else rr = v;
         if (rr > LIM) rr = LIM; else if (rr < -LIM) rr = -LIM;
         m[k] = rr[ELEM_W-1:0];
      end
   end
endmodule
`default_nettype wire
